/* hdl/ccbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin classifier and bin counter: shared types and constants
// Bin codes, window bounds, register indexes, payload structs and the
// per-bin state entry kept in the counter memory.
// ----------------------------------------------------------------------------
package ccbc_pkg;

	localparam int NUM_BINS  = 7;
	localparam int NUM_ROLLS = 5;
	localparam int BIN_W     = 3;
	localparam int ROLL_W    = 6;
	localparam int LIMIT_W   = 20;
	localparam int G_W       = 12;
	localparam int M_W       = 14;

	localparam logic [BIN_W-1:0] BIN_NICKEL  = 3'd0;
	localparam logic [BIN_W-1:0] BIN_DIME    = 3'd1;
	localparam logic [BIN_W-1:0] BIN_QUARTER = 3'd2;
	localparam logic [BIN_W-1:0] BIN_LOONIE  = 3'd3;
	localparam logic [BIN_W-1:0] BIN_TOONIE  = 3'd4;
	localparam logic [BIN_W-1:0] BIN_OTHER   = 3'd5;
	localparam logic [BIN_W-1:0] BIN_BENT    = 3'd6;
	localparam logic [BIN_W-1:0] BIN_REJECT  = 3'd7;

	localparam logic [1:0] FACE_BOTH = 2'd0;

	localparam logic [2:0] REG_BENT_LIMIT   = 3'd0;
	localparam logic [2:0] REG_OTHER_LIMIT  = 3'd1;
	localparam logic [2:0] REG_NICKEL_SIZE  = 3'd2;
	localparam logic [2:0] REG_DIME_SIZE    = 3'd3;
	localparam logic [2:0] REG_QUARTER_SIZE = 3'd4;
	localparam logic [2:0] REG_LOONIE_SIZE  = 3'd5;
	localparam logic [2:0] REG_TOONIE_SIZE  = 3'd6;

	localparam logic [LIMIT_W-1:0] BENT_LIMIT_RST  = 20'd25600;
	localparam logic [LIMIT_W-1:0] OTHER_LIMIT_RST = 20'd51200;

	typedef logic [ROLL_W-1:0] roll_size_t;

	localparam roll_size_t ROLL_SIZE_RST [NUM_ROLLS] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};

	// Inclusive Q8 windows, centre minus and plus tolerance.
	localparam logic [G_W-1:0] WIN_G_LO [NUM_ROLLS] = '{12'd921, 12'd333, 12'd1024, 12'd1664, 12'd1728};
	localparam logic [G_W-1:0] WIN_G_HI [NUM_ROLLS] = '{12'd1101, 12'd563, 12'd1228, 12'd1920, 12'd2010};
	localparam logic [M_W-1:0] WIN_M_LO [NUM_ROLLS] = '{14'd5171, 14'd4429, 14'd5837, 14'd6400, 14'd6886};
	localparam logic [M_W-1:0] WIN_M_HI [NUM_ROLLS] = '{14'd5581, 14'd4787, 14'd6297, 14'd6912, 14'd7450};

	typedef struct packed {
		logic [7:0] weight_raw;
		logic [7:0] diameter_raw;
		logic       is_bent;
		logic [1:0] face_match;
	} coin_t;

	typedef struct packed {
		logic [2:0]  bin;
		logic        replaced;
		logic [15:0] coins_in_current;
		logic [15:0] units_completed;
		logic [23:0] current_weight;
		logic [15:0] lifetime_coins;
		logic [31:0] lifetime_weight;
	} result_t;

	// One memory word per bin. Roll bins use only the low bits of fill_count
	// and leave both weights at zero.
	typedef struct packed {
		logic [15:0] fill_count;
		logic [15:0] units;
		logic [15:0] life;
		logic [23:0] fill_weight;
		logic [31:0] total_weight;
	} bin_entry_t;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage
`default_nettype wire

/* hdl/ccbc_classify.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin classifier
// Scales the raw readings to Q8 grams and millimetres and picks the bin.
// ----------------------------------------------------------------------------
module ccbc_classify (
	input  ccbc_pkg::coin_t                coin,
	output logic [ccbc_pkg::BIN_W-1:0]     bin,
	output logic [ccbc_pkg::G_W-1:0]       grams
);
	import ccbc_pkg::*;

	logic [19:0]          g_prod;
	logic [20:0]          m_prod;
	logic [M_W-1:0]       mm;
	logic [NUM_ROLLS-1:0] hit;

	// g = 10w + floor(2w/51) and m = 2560 + 30d + floor(2d/17). The small
	// quotients use reciprocals that are exact for numerators below 512.
	assign g_prod = {2'b00, coin.weight_raw, 1'b0} * 20'd1286;
	assign m_prod = {3'b000, coin.diameter_raw, 1'b0} * 21'd3856;

	assign grams = {1'b0, coin.weight_raw, 3'b000} + {3'b000, coin.weight_raw, 1'b0}
		+ {8'd0, g_prod[19:16]};
	assign mm = 14'd2560 + {1'b0, coin.diameter_raw, 5'b00000}
		- {5'd0, coin.diameter_raw, 1'b0} + {9'd0, m_prod[20:16]};

	always_comb begin
		for (int k = 0; k < NUM_ROLLS; k++) begin
			hit[k] = (grams >= WIN_G_LO[k]) && (grams <= WIN_G_HI[k])
				&& (mm >= WIN_M_LO[k]) && (mm <= WIN_M_HI[k]);
		end
	end

	always_comb begin
		if (coin.is_bent) begin
			bin = BIN_BENT;
		end else if (coin.face_match != FACE_BOTH) begin
			bin = BIN_OTHER;
		end else if (coin.weight_raw == 8'd0 || coin.diameter_raw == 8'd0) begin
			bin = BIN_REJECT;
		end else begin
			bin = BIN_OTHER;
			// Lowest coin index wins when windows overlap.
			for (int k = NUM_ROLLS - 1; k >= 0; k--) begin
				if (hit[k]) begin
					bin = BIN_W'(k);
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ccbc_state_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bin state memory
// One word per bin, with a registered synchronous read. Entries not
// yet written since reset read as zero.
// ----------------------------------------------------------------------------
module ccbc_state_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [ccbc_pkg::BIN_W-1:0]    rd_addr,
	output ccbc_pkg::bin_entry_t          rd_data,
	input  logic                          wr_en,
	input  logic [ccbc_pkg::BIN_W-1:0]    wr_addr,
	input  ccbc_pkg::bin_entry_t          wr_data
);
	import ccbc_pkg::*;

	bin_entry_t          mem [NUM_BINS];
	bin_entry_t          rd_q;
	logic [NUM_BINS-1:0] vld_q;
	logic                rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

/* hdl/ccbc_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bin update
// Applies one coin to its bin's state word: roll fill and completion, or
// container weight check and replacement, plus the saturating totals.
// ----------------------------------------------------------------------------
module ccbc_update (
	input  logic [ccbc_pkg::BIN_W-1:0]                         bin,
	input  logic [ccbc_pkg::G_W-1:0]                           grams,
	input  ccbc_pkg::bin_entry_t                               cur,
	input  logic [ccbc_pkg::LIMIT_W-1:0]                       bent_limit,
	input  logic [ccbc_pkg::LIMIT_W-1:0]                       other_limit,
	input  ccbc_pkg::roll_size_t [ccbc_pkg::NUM_ROLLS-1:0]     roll_size,
	output ccbc_pkg::bin_entry_t                               nxt,
	output ccbc_pkg::result_t                                  result
);
	import ccbc_pkg::*;

	roll_size_t         size;
	logic [ROLL_W-1:0]  fill_inc;
	logic               roll_full;
	logic [LIMIT_W-1:0] limit;
	logic [24:0]        fw_sum;
	logic [32:0]        tw_sum;
	logic               over;

	always_comb begin
		case (bin)
			BIN_NICKEL:  size = roll_size[0];
			BIN_DIME:    size = roll_size[1];
			BIN_QUARTER: size = roll_size[2];
			BIN_LOONIE:  size = roll_size[3];
			BIN_TOONIE:  size = roll_size[4];
			default:     size = '0;
		endcase
	end

	assign fill_inc  = cur.fill_count[ROLL_W-1:0] + ROLL_W'(1);
	assign roll_full = fill_inc >= size;

	assign limit  = (bin == BIN_BENT) ? bent_limit : other_limit;
	assign fw_sum = {1'b0, cur.fill_weight} + 25'(grams);
	assign tw_sum = {1'b0, cur.total_weight} + 33'(grams);
	assign over   = fw_sum > 25'(limit);

	always_comb begin
		nxt        = cur;
		nxt.life   = inc16(cur.life);
		result     = '0;
		result.bin = bin;
		case (bin)
			BIN_NICKEL, BIN_DIME, BIN_QUARTER, BIN_LOONIE, BIN_TOONIE: begin
				if (roll_full) begin
					nxt.fill_count = '0;
					nxt.units      = inc16(cur.units);
					result.replaced = 1'b1;
				end else begin
					nxt.fill_count = 16'(fill_inc);
				end
			end
			BIN_OTHER, BIN_BENT: begin
				nxt.total_weight = tw_sum[32] ? 32'hFFFF_FFFF : tw_sum[31:0];
				if (over) begin
					// The coin alone starts the fresh container.
					nxt.fill_weight = 24'(grams);
					nxt.fill_count  = 16'd1;
					nxt.units       = inc16(cur.units);
					result.replaced = 1'b1;
				end else begin
					nxt.fill_weight = fw_sum[24] ? 24'hFF_FFFF : fw_sum[23:0];
					nxt.fill_count  = inc16(cur.fill_count);
				end
				result.current_weight  = nxt.fill_weight;
				result.lifetime_weight = nxt.total_weight;
			end
			default: begin
				nxt = cur;
			end
		endcase
		if (bin != BIN_REJECT) begin
			result.coins_in_current = nxt.fill_count;
			result.units_completed  = nxt.units;
			result.lifetime_coins   = nxt.life;
		end
	end

endmodule
`default_nettype wire

/* hdl/coin_classify_and_bin_counter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin classifier and bin counter
// Routes each coin to a roll or container and reports that bin's counters.
// ----------------------------------------------------------------------------
// One coin is accepted per clock while results are taken: the coin is
// classified and its bin word read from the state memory in the accept
// cycle, updated in stage one and written back as it moves on, and then
// held in the output register. Back-to-back coins for the same bin are
// served by forwarding the word just written, so the rate stays one coin
// per cycle for any mix of bins. The memory needs no clearing pass; words
// not written since reset read as zero. Configuration writes take effect
// at once and are expected only while no coin is in flight.
module coin_classify_and_bin_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          coin_valid,
	output logic                          coin_ready,
	input  ccbc_pkg::coin_t               coin,
	output logic                          result_valid,
	input  logic                          result_ready,
	output ccbc_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [ccbc_pkg::LIMIT_W-1:0]  cfg_wdata
);
	import ccbc_pkg::*;

	logic [LIMIT_W-1:0]            bent_limit_q;
	logic [LIMIT_W-1:0]            other_limit_q;
	roll_size_t [NUM_ROLLS-1:0]    roll_size_q;

	logic [BIN_W-1:0] cls_bin;
	logic [G_W-1:0]   cls_grams;
	logic             accept;

	logic             vld_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [G_W-1:0]   grams_s1;
	logic             fwd_s1;
	bin_entry_t       fwd_entry_s1;
	bin_entry_t       mem_rd;
	bin_entry_t       cur_entry;
	bin_entry_t       nxt_entry;
	result_t          upd_result;
	logic             adv_s1;
	logic             wr_en;

	logic             out_vld_q;
	result_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bent_limit_q  <= BENT_LIMIT_RST;
			other_limit_q <= OTHER_LIMIT_RST;
			for (int k = 0; k < NUM_ROLLS; k++) begin
				roll_size_q[k] <= ROLL_SIZE_RST[k];
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BENT_LIMIT:   bent_limit_q   <= cfg_wdata;
				REG_OTHER_LIMIT:  other_limit_q  <= cfg_wdata;
				REG_NICKEL_SIZE:  roll_size_q[0] <= cfg_wdata[ROLL_W-1:0];
				REG_DIME_SIZE:    roll_size_q[1] <= cfg_wdata[ROLL_W-1:0];
				REG_QUARTER_SIZE: roll_size_q[2] <= cfg_wdata[ROLL_W-1:0];
				REG_LOONIE_SIZE:  roll_size_q[3] <= cfg_wdata[ROLL_W-1:0];
				REG_TOONIE_SIZE:  roll_size_q[4] <= cfg_wdata[ROLL_W-1:0];
				default: ;
			endcase
		end
	end

	ccbc_classify u_classify (
		.coin  (coin),
		.bin   (cls_bin),
		.grams (cls_grams)
	);

	assign adv_s1     = !out_vld_q || result_ready;
	assign coin_ready = !vld_s1 || adv_s1;
	assign accept     = coin_valid && coin_ready;
	assign wr_en      = vld_s1 && adv_s1 && (bin_s1 != BIN_REJECT);

	ccbc_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && (cls_bin != BIN_REJECT)),
		.rd_addr (cls_bin),
		.rd_data (mem_rd),
		.wr_en   (wr_en),
		.wr_addr (bin_s1),
		.wr_data (nxt_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (coin_ready) begin
			vld_s1 <= coin_valid;
			// The memory returns the old word when it is written in the
			// same cycle, so the fresh one is taken from here instead.
			fwd_s1 <= wr_en && (bin_s1 == cls_bin);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_s1       <= cls_bin;
			grams_s1     <= cls_grams;
			fwd_entry_s1 <= nxt_entry;
		end
	end

	assign cur_entry = fwd_s1 ? fwd_entry_s1 : mem_rd;

	ccbc_update u_update (
		.bin         (bin_s1),
		.grams       (grams_s1),
		.cur         (cur_entry),
		.bent_limit  (bent_limit_q),
		.other_limit (other_limit_q),
		.roll_size   (roll_size_q),
		.nxt         (nxt_entry),
		.result      (upd_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1) begin
			out_q <= upd_result;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule
`default_nettype wire

/* hdl/ccbc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coin classifier and bin counter: port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module ccbc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  ccbc_pkg::result_t             result
);
	import ccbc_pkg::*;

	logic roll_bin;

	assign roll_bin = result.bin < BIN_OTHER;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed before it was taken");

	a_reject_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bin == BIN_REJECT |-> !result.replaced
		&& result.coins_in_current == 16'd0 && result.units_completed == 16'd0
		&& result.lifetime_coins == 16'd0 && result.lifetime_weight == 32'd0)
		else $error("rejected coin reported nonzero counters");

	a_roll_no_weight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && roll_bin |-> result.current_weight == 24'd0
		&& result.lifetime_weight == 32'd0 && result.lifetime_coins != 16'd0)
		else $error("roll result carries weight or no lifetime count");

	a_replace_fill: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.replaced |->
		(roll_bin && result.coins_in_current == 16'd0)
		|| (!roll_bin && result.coins_in_current == 16'd1))
		else $error("completed roll or new container has wrong fill");

endmodule

bind coin_classify_and_bin_counter ccbc_checker u_ccbc_checker (.*);
`default_nettype wire
